@@ src/nsqrt_pkg.sv @@
// Shared types and constants for the Newton square root block.
`timescale 1ns / 1ps
package nsqrt_pkg;

    localparam int FracBits   = 30;
    localparam int ExpWidth   = 8;
    localparam int DataWidth  = 32;
    localparam int ScaleWidth = 16;
    localparam int StepWidth  = 11;

    // Numerator bit count of the long division: M has 34 bits, then FracBits zeros.
    localparam int DivBits    = 34 + FracBits;
    localparam int DivCntW    = $clog2(DivBits + 1);
    localparam int ProdWidth  = DataWidth + ScaleWidth;
    localparam int MulCntW    = $clog2(ScaleWidth + 1);

    // Configuration register indexes.
    localparam logic [0:0] CfgMatchScale = 1'b0;
    localparam logic [0:0] CfgStepLimit  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_CONVERGED  = 2'd0,
        ST_STEP_LIMIT = 2'd1,
        ST_ZERO_GUESS = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_DECIDE,
        S_OUT
    } t_state;

    // Start strobe from the sequencer to a serial unit; done returns on the unit's own port.
    typedef struct packed {
        logic start;
    } t_unit_ctl;

endpackage

@@ src/nsqrt_div.sv @@
// Bit-serial restoring divider: floor(M * 2^FracBits / den), saturated at 32 bits.
`timescale 1ns / 1ps
module nsqrt_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nsqrt_pkg::t_unit_ctl          i_ctl,
    input  logic [33:0]                   i_num,
    input  logic [33:0]                   i_den,
    output logic                          o_done,
    output logic [nsqrt_pkg::DataWidth-1:0] o_quot
);
    logic [nsqrt_pkg::DivBits-1:0]   r_num, n_num;
    logic [34:0]                     r_rem, n_rem;
    logic [32:0]                     r_q, n_q;
    logic [33:0]                     r_den;
    logic                            r_sat, n_sat;
    logic [nsqrt_pkg::DivCntW-1:0]   r_cnt, n_cnt;
    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [35:0]                     v_shift;
    logic [32:0]                     v_q;

    // One quotient bit per cycle.
    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_q    = r_q;
        n_sat  = r_sat;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        v_shift = '0;
        v_q     = '0;
        if (i_ctl.start) begin
            n_num  = {i_num, {nsqrt_pkg::FracBits{1'b0}}};
            n_rem  = '0;
            n_q    = '0;
            n_sat  = 1'b0;
            n_cnt  = nsqrt_pkg::DivCntW'(nsqrt_pkg::DivBits);
            n_busy = 1'b1;
        end else if (r_busy) begin
            v_shift = {r_rem, r_num[nsqrt_pkg::DivBits-1]};
            v_q     = {r_q[31:0], 1'b0};
            if (v_shift >= {2'b00, r_den}) begin
                v_shift = v_shift - {2'b00, r_den};
                v_q[0]  = 1'b1;
            end
            if (v_q[32]) begin
                n_sat = 1'b1;
                v_q   = {1'b0, 32'hFFFF_FFFF};
            end
            n_rem = v_shift[34:0];
            n_q   = v_q;
            n_num = {r_num[nsqrt_pkg::DivBits-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == nsqrt_pkg::DivCntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_sat <= n_sat;
        r_cnt <= n_cnt;
        if (i_ctl.start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_sat || r_den == '0) ? '1 : r_q[31:0];
endmodule

@@ src/nsqrt_mul.sv @@
// Bit-serial shift-add scaler: floor(y * scale / 2^FracBits) for two iterates at once.
`timescale 1ns / 1ps
module nsqrt_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  nsqrt_pkg::t_unit_ctl             i_ctl,
    input  logic [nsqrt_pkg::DataWidth-1:0]  i_a,
    input  logic [nsqrt_pkg::DataWidth-1:0]  i_b,
    input  logic [nsqrt_pkg::ScaleWidth-1:0] i_scale,
    output logic                             o_done,
    output logic                             o_equal
);
    logic [nsqrt_pkg::ProdWidth-1:0]  r_pa, r_pb, n_pa, n_pb;
    logic [nsqrt_pkg::ProdWidth-1:0]  r_a, r_b, n_a, n_b;
    logic [nsqrt_pkg::ScaleWidth-1:0] r_sc, n_sc;
    logic [nsqrt_pkg::MulCntW-1:0]    r_cnt, n_cnt;
    logic                             r_busy, n_busy, r_done, n_done;

    // One multiplier bit per cycle, both products in parallel.
    always_comb begin
        n_pa = r_pa; n_pb = r_pb; n_a = r_a; n_b = r_b; n_sc = r_sc;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_ctl.start) begin
            n_pa = '0; n_pb = '0;
            n_a  = nsqrt_pkg::ProdWidth'(i_a);
            n_b  = nsqrt_pkg::ProdWidth'(i_b);
            n_sc = i_scale;
            n_cnt = nsqrt_pkg::MulCntW'(nsqrt_pkg::ScaleWidth);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_sc[0]) begin
                n_pa = r_pa + r_a;
                n_pb = r_pb + r_b;
            end
            n_a  = {r_a[nsqrt_pkg::ProdWidth-2:0], 1'b0};
            n_b  = {r_b[nsqrt_pkg::ProdWidth-2:0], 1'b0};
            n_sc = r_sc >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == nsqrt_pkg::MulCntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_pa <= n_pa; r_pb <= n_pb; r_a <= n_a; r_b <= n_b;
        r_sc <= n_sc; r_cnt <= n_cnt;
    end

    assign o_done  = r_done;
    assign o_equal = r_pa[nsqrt_pkg::ProdWidth-1:nsqrt_pkg::FracBits]
                  == r_pb[nsqrt_pkg::ProdWidth-1:nsqrt_pkg::FracBits];
endmodule

@@ src/newton_sqrt_with_exponent_top.sv @@
// Top level: sequencer for the Newton square root with exponent handling.
// Sequence: each Newton step runs the divider, then the scaler, then a decide step;
// a zero guess goes straight to the output.
// Throughput: one item at a time; the bit-serial divider sets the per-step cost.
// Reset: synchronous active-low; registers return to match_scale 1000 and step_limit 1000,
// and the block is empty and ready.
`timescale 1ns / 1ps
module newton_sqrt_with_exponent_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_mantissa,
    input  logic signed [7:0] i_exponent_in,
    input  logic [31:0] i_start_guess,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_root_mantissa,
    output logic signed [6:0] o_root_exponent,
    output logic [10:0] o_steps_taken,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    nsqrt_pkg::t_state r_state, n_state;
    logic [15:0] r_scale;
    logic [10:0] r_limit;
    logic [32:0] r_m;
    logic [31:0] r_y, r_next;
    logic [11:0] r_steps;
    logic [6:0]  r_exp;
    logic [1:0]  r_status;
    logic        r_valid;
    logic [31:0] r_out_root;
    logic [6:0]  r_out_exp;
    logic [10:0] r_out_steps;
    logic [1:0]  r_out_status;
    nsqrt_pkg::t_unit_ctl w_div_ctl, w_mul_ctl;
    logic        w_div_done, w_mul_done, w_equal;
    logic [31:0] w_quot;
    logic [32:0] w_sum;
    logic [31:0] w_next;
    logic        w_out_load;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != nsqrt_pkg::S_IDLE);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 16'd1000;
            r_limit <= 11'd1000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nsqrt_pkg::CfgMatchScale: r_scale <= i_cfg_data;
                nsqrt_pkg::CfgStepLimit:  r_limit <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    nsqrt_div u_div (
        .i_clk, .i_rst_n, .i_ctl(w_div_ctl),
        .i_num({1'b0, r_m}), .i_den({1'b0, r_y, 1'b0}),
        .o_done(w_div_done), .o_quot(w_quot)
    );

    // Next iterate, saturated at 32 bits; valid while the divider reports done.
    assign w_sum  = {2'b00, r_y[31:1]} + {1'b0, w_quot};
    assign w_next = w_sum[32] ? '1 : w_sum[31:0];

    nsqrt_mul u_mul (
        .i_clk, .i_rst_n, .i_ctl(w_mul_ctl),
        .i_a(r_y), .i_b(w_next), .i_scale(r_scale),
        .o_done(w_mul_done), .o_equal(w_equal)
    );

    // The result register takes a new result once it is empty or being read.
    assign w_out_load = (r_state == nsqrt_pkg::S_OUT) && (!r_valid || !i_stall);

    // Next state and unit starts.
    always_comb begin
        n_state = r_state;
        w_div_ctl.start = 1'b0;
        w_mul_ctl.start = 1'b0;
        unique case (r_state)
            nsqrt_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_start_guess == '0) ? nsqrt_pkg::S_OUT : nsqrt_pkg::S_DECIDE;
                end
            end
            nsqrt_pkg::S_DIV: if (w_div_done) begin
                w_mul_ctl.start = 1'b1;
                n_state = nsqrt_pkg::S_MUL;
            end
            nsqrt_pkg::S_MUL: if (w_mul_done) n_state = nsqrt_pkg::S_DECIDE;
            nsqrt_pkg::S_DECIDE: begin
                if (r_status == nsqrt_pkg::ST_ZERO_GUESS) begin
                    w_div_ctl.start = 1'b1;
                    n_state = nsqrt_pkg::S_DIV;
                end else begin
                    n_state = nsqrt_pkg::S_OUT;
                end
            end
            nsqrt_pkg::S_OUT: if (w_out_load) n_state = nsqrt_pkg::S_IDLE;
            default: n_state = nsqrt_pkg::S_IDLE;
        endcase
    end

    // Sequencer and datapath registers; r_status holds ZERO_GUESS as "keep going".
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nsqrt_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) r_valid <= 1'b1;
            else if (!i_stall) r_valid <= 1'b0;
        end
        unique case (r_state)
            nsqrt_pkg::S_IDLE: if (i_valid) begin
                r_m      <= i_exponent_in[0] ? {i_mantissa, 1'b0} : {1'b0, i_mantissa};
                r_y      <= i_start_guess;
                r_exp    <= i_exponent_in[7:1];
                r_steps  <= '0;
                // A zero guess reports this status; otherwise the first decide starts the loop.
                r_status <= nsqrt_pkg::ST_ZERO_GUESS;
            end
            nsqrt_pkg::S_DIV: if (w_div_done) r_next <= w_next;
            nsqrt_pkg::S_MUL: if (w_mul_done) begin
                if (w_equal) r_status <= nsqrt_pkg::ST_CONVERGED;
                else if (r_steps > {1'b0, r_limit}) r_status <= nsqrt_pkg::ST_STEP_LIMIT;
                else begin
                    r_y      <= r_next;
                    r_steps  <= r_steps + 1'b1;
                    r_status <= nsqrt_pkg::ST_ZERO_GUESS;
                end
            end
            nsqrt_pkg::S_DECIDE: ;
            nsqrt_pkg::S_OUT: ;
            default: ;
        endcase
        if (w_out_load) begin
            r_out_root   <= r_y;
            r_out_exp    <= r_exp;
            r_out_steps  <= r_steps[11] ? 11'h7FF : r_steps[10:0];
            r_out_status <= r_status;
        end
    end

    // Output register; a zero guess reports mantissa zero.
    assign o_valid         = r_valid;
    assign o_root_mantissa = r_out_root;
    assign o_root_exponent = r_out_exp;
    assign o_steps_taken   = r_out_steps;
    assign o_status        = r_out_status;
endmodule
